// ===== rtl/rstt_pkg.sv =====
// ----------------------------------------------------------------------------
// rstt_pkg
// Shared types and constants for the register status tag table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rstt_pkg;

    // field widths of one transaction
    localparam int IDX_W = 6;
    localparam int TAG_W = 6;

    // command codes
    typedef enum logic [1:0] {
        CMD_QUERY   = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_FLUSH   = 2'd3
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/register_status_tag_table_unit.sv =====
// Throughput: one transaction per cycle while the output is not stalled;
// the table is a single registered read stage followed by the result
// register, and stall backs up through both.
// Reset: synchronous, active low; clears the busy and tag-valid bits of both
// tables at once, so tags read as zero until written. No clearing pass.
// ----------------------------------------------------------------------------
// register_status_tag_table_unit
// Busy bit and reorder-buffer tag per architectural register, one table for
// integer and one for floating-point registers: query, allocate, release on
// tag match and flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module register_status_tag_table_unit
    import rstt_pkg::*;
#(
    parameter int INT_REG_COUNT = 32,
    parameter int FP_REG_COUNT  = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // command channel
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [1:0]       i_command,
    input  wire logic             i_integer_file,
    input  wire logic [IDX_W-1:0] i_reg_index,
    input  wire logic [TAG_W-1:0] i_rob_tag,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_busy_res,
    output logic [TAG_W-1:0]      o_tag_out,
    output logic                  o_index_error
);

    localparam int INT_AW = $clog2(INT_REG_COUNT);
    localparam int FP_AW  = $clog2(FP_REG_COUNT);

    // table storage
    logic [TAG_W-1:0]         r_int_tag_mem [INT_REG_COUNT];
    logic [TAG_W-1:0]         r_fp_tag_mem  [FP_REG_COUNT];
    logic [INT_REG_COUNT-1:0] r_int_busy, n_int_busy;
    logic [INT_REG_COUNT-1:0] r_int_vld,  n_int_vld;
    logic [FP_REG_COUNT-1:0]  r_fp_busy,  n_fp_busy;
    logic [FP_REG_COUNT-1:0]  r_fp_vld,   n_fp_vld;

    // read stage
    logic             r_s1_valid;
    t_cmd             r_s1_cmd;
    logic             r_s1_int;
    logic [IDX_W-1:0] r_s1_idx;
    logic [TAG_W-1:0] r_s1_tag;
    logic             r_s1_err;
    logic [TAG_W-1:0] r_s1_mem_tag;

    logic             in_acc;
    logic             s1_move;
    logic             in_err;
    t_cmd             in_cmd;
    logic [INT_AW-1:0] in_int_addr;
    logic [FP_AW-1:0]  in_fp_addr;
    logic [INT_AW-1:0] s1_int_addr;
    logic [FP_AW-1:0]  s1_fp_addr;
    logic             s1_busy;
    logic             s1_vld;
    logic [TAG_W-1:0] s1_tag;
    logic             s1_rel_hit;
    logic             n_busy_res;
    logic [TAG_W-1:0] n_tag_out;

    // handshake
    assign s1_move    = r_s1_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_acc     = i_in_valid && !o_in_stall;

    // input decode and range check against the selected table
    assign in_cmd      = t_cmd'(i_command);
    assign in_int_addr = i_reg_index[INT_AW-1:0];
    assign in_fp_addr  = i_reg_index[FP_AW-1:0];

    always_comb begin
        if (in_cmd == CMD_FLUSH) begin
            in_err = 1'b0;
        end else if (i_integer_file) begin
            in_err = ({1'b0, i_reg_index} >= (IDX_W+1)'(INT_REG_COUNT));
        end else begin
            in_err = ({1'b0, i_reg_index} >= (IDX_W+1)'(FP_REG_COUNT));
        end
    end

    // tag memories: write on allocate, registered read on every transaction
    always_ff @(posedge i_clk) begin
        if (in_acc && in_cmd == CMD_ALLOC && !in_err && i_integer_file) begin
            r_int_tag_mem[in_int_addr] <= i_rob_tag;
        end
        if (in_acc && in_cmd == CMD_ALLOC && !in_err && !i_integer_file) begin
            r_fp_tag_mem[in_fp_addr] <= i_rob_tag;
        end
        if (in_acc) begin
            if (i_integer_file) begin
                r_s1_mem_tag <= r_int_tag_mem[in_int_addr];
            end else begin
                r_s1_mem_tag <= r_fp_tag_mem[in_fp_addr];
            end
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd <= in_cmd;
            r_s1_int <= i_integer_file;
            r_s1_idx <= i_reg_index;
            r_s1_tag <= i_rob_tag;
            r_s1_err <= in_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // entry lookup for the transaction in the read stage
    assign s1_int_addr = r_s1_idx[INT_AW-1:0];
    assign s1_fp_addr  = r_s1_idx[FP_AW-1:0];

    always_comb begin
        if (r_s1_int) begin
            s1_busy = r_int_busy[s1_int_addr];
            s1_vld  = r_int_vld[s1_int_addr];
        end else begin
            s1_busy = r_fp_busy[s1_fp_addr];
            s1_vld  = r_fp_vld[s1_fp_addr];
        end
        s1_tag     = s1_vld ? r_s1_mem_tag : '0;
        s1_rel_hit = s1_move && (r_s1_cmd == CMD_RELEASE) && !r_s1_err
                     && (s1_tag == r_s1_tag);
    end

    // result of the read stage; integer register zero never reads busy
    always_comb begin
        n_busy_res = 1'b0;
        n_tag_out  = '0;
        if (r_s1_cmd == CMD_QUERY && !r_s1_err) begin
            n_busy_res = s1_busy && !(r_s1_int && r_s1_idx == '0);
            n_tag_out  = s1_tag;
        end
    end

    // busy and tag-valid bits: release from the read stage first, then the
    // newly accepted transaction, which is later in order and wins
    always_comb begin
        n_int_busy = r_int_busy;
        n_int_vld  = r_int_vld;
        n_fp_busy  = r_fp_busy;
        n_fp_vld   = r_fp_vld;
        if (s1_rel_hit && r_s1_int) begin
            n_int_busy[s1_int_addr] = 1'b0;
        end
        if (s1_rel_hit && !r_s1_int) begin
            n_fp_busy[s1_fp_addr] = 1'b0;
        end
        if (in_acc) begin
            case (in_cmd)
                CMD_FLUSH: begin
                    n_int_busy = '0;
                    n_int_vld  = '0;
                    n_fp_busy  = '0;
                    n_fp_vld   = '0;
                end
                CMD_ALLOC: begin
                    if (!in_err && i_integer_file) begin
                        n_int_busy[in_int_addr] = 1'b1;
                        n_int_vld[in_int_addr]  = 1'b1;
                    end
                    if (!in_err && !i_integer_file) begin
                        n_fp_busy[in_fp_addr] = 1'b1;
                        n_fp_vld[in_fp_addr]  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_busy <= '0;
            r_int_vld  <= '0;
            r_fp_busy  <= '0;
            r_fp_vld   <= '0;
        end else begin
            r_int_busy <= n_int_busy;
            r_int_vld  <= n_int_vld;
            r_fp_busy  <= n_fp_busy;
            r_fp_vld   <= n_fp_vld;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_move) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            o_busy_res    <= n_busy_res;
            o_tag_out     <= n_tag_out;
            o_index_error <= r_s1_err;
        end
    end

endmodule

`default_nettype wire
